// ===== src/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int WORD_W       = 32;
  localparam int CNT_W        = $clog2(WORD_W);
  localparam int KEY_BITS_DEF = 32;
  localparam int REG_IDX_W    = 2;

  localparam logic [REG_IDX_W-1:0] REG_EXPONENT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_SQUARE,
    OP_MULT
  } op_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] opa;
    logic [WORD_W-1:0] opb;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] product;
  } mm_rsp_t;

endpackage

// ===== src/mexp_modmul.sv =====
`timescale 1ns / 1ps

// Interleaved modular multiplier: scans opa MSB first, one bit per cycle.
// r = 2r + a_j*b, reduced after the double and after the add, so r < n throughout.
module mexp_modmul (
  input  logic                           clk,
  input  logic                           rst,
  input  mexp_pkg::mm_req_t              req,
  input  logic [mexp_pkg::WORD_W-1:0]    n,
  output mexp_pkg::mm_rsp_t              rsp
);

  logic [mexp_pkg::WORD_W-1:0] a_sr;
  logic [mexp_pkg::WORD_W-1:0] b_reg;
  logic [mexp_pkg::WORD_W-1:0] r;
  logic [mexp_pkg::WORD_W-1:0] r_next;
  logic [mexp_pkg::CNT_W-1:0]  cnt;
  logic                        run;
  logic                        done;

  logic [mexp_pkg::WORD_W:0]   dbl;
  logic [mexp_pkg::WORD_W+1:0] dbl_sub;
  logic [mexp_pkg::WORD_W-1:0] dbl_red;
  logic [mexp_pkg::WORD_W:0]   add;
  logic [mexp_pkg::WORD_W+1:0] add_sub;

  always_comb begin
    dbl     = {r, 1'b0};
    dbl_sub = {1'b0, dbl} - {2'b00, n};
    // dbl < n when the subtract borrows, so its top bit is clear
    dbl_red = dbl_sub[mexp_pkg::WORD_W+1] ? dbl[mexp_pkg::WORD_W-1:0]
                                          : dbl_sub[mexp_pkg::WORD_W-1:0];
    add     = {1'b0, dbl_red} + (a_sr[mexp_pkg::WORD_W-1] ? {1'b0, b_reg} : '0);
    add_sub = {1'b0, add} - {2'b00, n};
    r_next  = add_sub[mexp_pkg::WORD_W+1] ? add[mexp_pkg::WORD_W-1:0]
                                          : add_sub[mexp_pkg::WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == mexp_pkg::CNT_W'(mexp_pkg::WORD_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sr  <= req.opa;
      b_reg <= req.opb;
      r     <= '0;
      cnt   <= '0;
    end else if (run) begin
      r    <= r_next;
      a_sr <= {a_sr[mexp_pkg::WORD_W-2:0], 1'b0};
      cnt  <= cnt + 1'b1;
    end
  end

  assign rsp.done    = done;
  assign rsp.product = r;

endmodule

// ===== src/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// A modulus <= 1 skips the multiplier; otherwise one reduction, KEY_BITS squarings and
// one multiply per set bit in the scanned exponent bits run in turn. One transaction at
// a time, next accepted the cycle after done. Every modular multiply runs in the
// bit-serial multiplier. Synchronous active-high reset: idle, exponent = 1, modulus = 1.
// The result is shown for one cycle on done; the receiver cannot stall.
module modular_exponentiation #(
  parameter int KEY_BITS = mexp_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mexp_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [mexp_pkg::WORD_W-1:0]       cfg_data,
  input  logic                              start,
  input  logic [mexp_pkg::WORD_W-1:0]       message,
  output logic                              busy,
  output logic                              done,
  output logic [mexp_pkg::WORD_W-1:0]       power_result
);

  localparam int IDX_W = $clog2(KEY_BITS);

  mexp_pkg::state_t state;
  mexp_pkg::state_t state_next;
  mexp_pkg::op_t    op;

  logic [mexp_pkg::WORD_W-1:0]          exponent;
  logic [mexp_pkg::WORD_W-1:0]          modulus;
  logic [mexp_pkg::WORD_W-1:0]          msg;
  logic [mexp_pkg::WORD_W-1:0]          acc;
  logic [mexp_pkg::WORD_W-1:0]          base;
  logic [KEY_BITS-1:0]                  exp_sr;
  logic [IDX_W-1:0]                     idx;
  logic [KEY_BITS+mexp_pkg::WORD_W-1:0] exp_ext;
  logic                                 trivial;
  logic                                 accept;

  mexp_pkg::mm_req_t mm_req;
  mexp_pkg::mm_rsp_t mm_rsp;

  assign exp_ext = {{KEY_BITS{1'b0}}, exponent};
  assign trivial = (modulus[mexp_pkg::WORD_W-1:1] == '0);
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= mexp_pkg::WORD_W'(1);
      modulus  <= mexp_pkg::WORD_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == mexp_pkg::REG_EXPONENT) begin
        exponent <= cfg_data;
      end else if (cfg_index == mexp_pkg::REG_MODULUS) begin
        modulus <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = trivial ? mexp_pkg::ST_DONE : mexp_pkg::ST_ISSUE;
        end
      end
      mexp_pkg::ST_ISSUE: begin
        state_next = mexp_pkg::ST_WAIT;
      end
      mexp_pkg::ST_WAIT: begin
        if (mm_rsp.done) begin
          unique case (op)
            mexp_pkg::OP_SQUARE: begin
              if (!exp_sr[KEY_BITS-1] && idx == '0) begin
                state_next = mexp_pkg::ST_DONE;
              end else begin
                state_next = mexp_pkg::ST_ISSUE;
              end
            end
            mexp_pkg::OP_MULT: begin
              state_next = (idx == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_ISSUE;
            end
            default: begin
              state_next = mexp_pkg::ST_ISSUE;
            end
          endcase
        end
      end
      mexp_pkg::ST_DONE: begin
        state_next = mexp_pkg::ST_IDLE;
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = (state != mexp_pkg::ST_IDLE);
    done         = (state == mexp_pkg::ST_DONE);
    power_result = acc;
    mm_req.start = (state == mexp_pkg::ST_ISSUE);
    unique case (op)
      mexp_pkg::OP_SQUARE: begin
        mm_req.opa = acc;
        mm_req.opb = acc;
      end
      mexp_pkg::OP_MULT: begin
        mm_req.opa = acc;
        mm_req.opb = base;
      end
      default: begin
        // message mod n as message * 1
        mm_req.opa = msg;
        mm_req.opb = mexp_pkg::WORD_W'(1);
      end
    endcase
  end

  // left-to-right square-and-multiply; exp_sr MSB is the current exponent bit
  always_ff @(posedge clk) begin
    if (accept) begin
      msg    <= message;
      acc    <= trivial ? '0 : mexp_pkg::WORD_W'(1);
      op     <= mexp_pkg::OP_REDUCE;
      idx    <= IDX_W'(KEY_BITS - 1);
      exp_sr <= exp_ext[KEY_BITS-1:0];
    end else if (state == mexp_pkg::ST_WAIT && mm_rsp.done) begin
      unique case (op)
        mexp_pkg::OP_SQUARE: begin
          acc <= mm_rsp.product;
          if (exp_sr[KEY_BITS-1]) begin
            op <= mexp_pkg::OP_MULT;
          end else begin
            idx    <= idx - 1'b1;
            exp_sr <= {exp_sr[KEY_BITS-2:0], 1'b0};
          end
        end
        mexp_pkg::OP_MULT: begin
          acc    <= mm_rsp.product;
          op     <= mexp_pkg::OP_SQUARE;
          idx    <= idx - 1'b1;
          exp_sr <= {exp_sr[KEY_BITS-2:0], 1'b0};
        end
        default: begin
          base <= mm_rsp.product;
          op   <= mexp_pkg::OP_SQUARE;
        end
      endcase
    end
  end

  mexp_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .n   (modulus),
    .rsp (mm_rsp)
  );

endmodule
